// File: design/cae_pkg.sv
// Shared types, constants and helpers for the collider extent block.
// No dependencies; every other design file imports this package.
package cae_pkg;

    localparam int SLOT_W = 16;
    localparam int QUAT_W = 64;
    localparam int SCL_W  = 32;
    localparam int SZ_W   = 31;
    localparam int EXT_W  = 31;
    localparam int R_W    = 30;   // clamped rotation entry, signed, Q.28
    localparam int M_W    = 30;   // |combined| entry, unsigned, Q.28
    localparam int P_W    = 63;   // size * |scale|, Q.32

    localparam logic [EXT_W-1:0] EXT_MAX = {EXT_W{1'b1}};
    localparam logic signed [35:0] ONE_Q28 = 36'sh010000000;

    // product slots of one quaternion
    localparam int QP_XX = 0;
    localparam int QP_YY = 1;
    localparam int QP_ZZ = 2;
    localparam int QP_XY = 3;
    localparam int QP_XZ = 4;
    localparam int QP_YZ = 5;
    localparam int QP_WX = 6;
    localparam int QP_WY = 7;
    localparam int QP_WZ = 8;

    typedef enum logic [1:0] {
        K_SPHERE  = 2'd0,
        K_BOX     = 2'd1,
        K_CAPSULE = 2'd2,
        K_NONE    = 2'd3
    } t_kind;

    typedef logic [8:0][31:0]          t_qp;
    typedef logic [2:0][2:0][R_W-1:0]  t_rmat;

    typedef struct packed {
        t_kind                   kind;
        logic [SLOT_W-1:0]       slot;
        logic [QUAT_W-1:0]       qw;
        logic [QUAT_W-1:0]       qo;
        logic [2:0][SCL_W-1:0]   scl;   // absolute scale
        logic [2:0][SZ_W-1:0]    sz;
    } t_item;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [EXT_W-1:0]  ext_x;
        logic [EXT_W-1:0]  ext_y;
        logic [EXT_W-1:0]  ext_z;
        logic              updated;
        logic              saturated;
    } t_result;

    function automatic logic [SCL_W-1:0] abs_scl(input logic [SCL_W-1:0] v);
        return v[SCL_W-1] ? (~v + SCL_W'(1)) : v;
    endfunction

    function automatic t_qp quat_prods(input logic [QUAT_W-1:0] q);
        logic signed [15:0] w, x, y, z;
        t_qp p;
        w = q[63:48];
        x = q[47:32];
        y = q[31:16];
        z = q[15:0];
        p[QP_XX] = 32'(x * x);
        p[QP_YY] = 32'(y * y);
        p[QP_ZZ] = 32'(z * z);
        p[QP_XY] = 32'(x * y);
        p[QP_XZ] = 32'(x * z);
        p[QP_YZ] = 32'(y * z);
        p[QP_WX] = 32'(w * x);
        p[QP_WY] = 32'(w * y);
        p[QP_WZ] = 32'(w * z);
        return p;
    endfunction

    function automatic logic [R_W-1:0] clamp_unit(input logic signed [35:0] v);
        logic [R_W-1:0] r;
        if (v > ONE_Q28) begin
            r = R_W'(ONE_Q28);
        end else if (v < -ONE_Q28) begin
            r = R_W'(-ONE_Q28);
        end else begin
            r = R_W'(v);
        end
        return r;
    endfunction

    function automatic t_rmat quat_mat(input t_qp p);
        logic signed [35:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
        t_rmat r;
        xx = 36'($signed(p[QP_XX]));
        yy = 36'($signed(p[QP_YY]));
        zz = 36'($signed(p[QP_ZZ]));
        xy = 36'($signed(p[QP_XY]));
        xz = 36'($signed(p[QP_XZ]));
        yz = 36'($signed(p[QP_YZ]));
        wx = 36'($signed(p[QP_WX]));
        wy = 36'($signed(p[QP_WY]));
        wz = 36'($signed(p[QP_WZ]));
        r[0][0] = clamp_unit(ONE_Q28 - ((yy + zz) <<< 1));
        r[0][1] = clamp_unit((xy - wz) <<< 1);
        r[0][2] = clamp_unit((xz + wy) <<< 1);
        r[1][0] = clamp_unit((xy + wz) <<< 1);
        r[1][1] = clamp_unit(ONE_Q28 - ((xx + zz) <<< 1));
        r[1][2] = clamp_unit((yz - wx) <<< 1);
        r[2][0] = clamp_unit((xz - wy) <<< 1);
        r[2][1] = clamp_unit((yz + wx) <<< 1);
        r[2][2] = clamp_unit(ONE_Q28 - ((xx + yy) <<< 1));
        return r;
    endfunction

endpackage

// File: design/cae_front.sv
// Front end: takes a collider word, decodes its kind, folds scale signs.
// Depends on cae_pkg.
module cae_front import cae_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_command,
    input  logic [SLOT_W-1:0]        i_entry_index,
    input  logic [QUAT_W-1:0]        i_world_rotation,
    input  logic [QUAT_W-1:0]        i_offset_rotation,
    input  logic signed [SCL_W-1:0]  i_scale_x,
    input  logic signed [SCL_W-1:0]  i_scale_y,
    input  logic signed [SCL_W-1:0]  i_scale_z,
    input  logic [SZ_W-1:0]          i_size_a,
    input  logic [SZ_W-1:0]          i_size_b,
    input  logic [SZ_W-1:0]          i_size_c,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_item                    o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item.kind   = t_kind'(i_command);
        n_item.slot   = i_entry_index;
        n_item.qw     = i_world_rotation;
        n_item.qo     = i_offset_rotation;
        n_item.scl[0] = abs_scl(i_scale_x);
        n_item.scl[1] = abs_scl(i_scale_y);
        n_item.scl[2] = abs_scl(i_scale_z);
        n_item.sz[0]  = i_size_a;
        n_item.sz[1]  = i_size_b;
        n_item.sz[2]  = i_size_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// File: design/cae_queue.sv
// Small FIFO of decoded items between front and back end.
// Depends on cae_pkg.
module cae_queue import cae_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item           r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            push;
    logic            pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= wrap_inc(r_wr);
            end
            if (pop) begin
                r_rd <= wrap_inc(r_rd);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// File: design/cae_back.sv
// Back end: seven-stage arithmetic pipeline, rotation matrices to extents.
// Depends on cae_pkg.
module cae_back import cae_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_item   i_item,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    localparam int NSTG = 7;

    typedef struct packed {
        t_kind                 kind;
        logic [SLOT_W-1:0]     slot;
        logic [SZ_W-1:0]       sz0;
        logic [SZ_W-1:0]       sz1;
        logic [2:0][P_W-1:0]   p;
        logic [47:0]           sph;
    } t_side;

    logic [NSTG-1:0]  r_vld;
    logic             en;
    t_side            r_sd [NSTG-1];
    t_side            n_sd0;
    t_side            n_sd1;

    t_qp              r1_qpw, r1_qpo;
    logic [SCL_W-1:0] r1_mx;
    t_rmat            r2_rw, r2_ro;
    logic [2:0][2:0][2:0][59:0] r3_cp;
    logic [2:0][2:0][M_W-1:0]   r4_m;
    logic [2:0][2:0][60:0]      r5_bh;
    logic [2:0][2:0][29:0]      r5_bl;
    logic [2:0][31:0]           r5_cap;
    logic [2:0][63:0]           r6_bs;
    logic [2:0][32:0]           r6_cap;
    t_result                    r_out;

    logic [SCL_W-1:0]           n_mx;
    logic [62:0]                sph_p;
    logic [63:0]                sph_r;
    logic [2:0][2:0][M_W-1:0]   n_m;
    logic [2:0][2:0][60:0]      n_bh;
    logic [2:0][2:0][29:0]      n_bl;
    logic [2:0][31:0]           n_cap;
    logic [2:0][63:0]           n_bs;
    logic [2:0][32:0]           n_cap6;
    t_result                    n_out;

    assign en       = !r_vld[NSTG-1] || i_ready;
    assign o_ready  = en;
    assign o_valid  = r_vld[NSTG-1];
    assign o_result = r_out;

    // stage 1: scale max, size products, quaternion products
    always_comb begin
        n_mx = i_item.scl[0];
        if (i_item.scl[1] > n_mx) begin
            n_mx = i_item.scl[1];
        end
        if (i_item.scl[2] > n_mx) begin
            n_mx = i_item.scl[2];
        end
        n_sd0.kind = i_item.kind;
        n_sd0.slot = i_item.slot;
        n_sd0.sz0  = i_item.sz[0];
        n_sd0.sz1  = i_item.sz[1];
        n_sd0.sph  = '0;
        for (int j = 0; j < 3; j++) begin
            n_sd0.p[j] = P_W'(i_item.sz[j]) * P_W'(i_item.scl[j]);
        end
    end

    // stage 2: sphere product and rounding
    always_comb begin
        sph_p     = 63'(r_sd[0].sz0) * 63'(r1_mx);
        sph_r     = 64'(sph_p) + 64'h8000;
        n_sd1     = r_sd[0];
        n_sd1.sph = sph_r[63:16];
    end

    // stage 4: sum of products, magnitude, round to Q.28
    always_comb begin
        logic signed [61:0] s;
        logic [61:0]        a;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                s = 62'($signed(r3_cp[i][j][0])) + 62'($signed(r3_cp[i][j][1]))
                  + 62'($signed(r3_cp[i][j][2]));
                a = s[61] ? 62'(-s) : 62'(s);
                a = a + (62'd1 << 27);
                n_m[i][j] = a[57:28];
            end
        end
    end

    // stage 5: per-term products for box and capsule
    always_comb begin
        logic [61:0] lo;
        logic [60:0] c;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_bh[i][j] = 61'(r4_m[i][j]) * 61'(r_sd[3].p[j][62:32]);
                lo         = 62'(r4_m[i][j]) * 62'(r_sd[3].p[j][31:0]);
                n_bl[i][j] = lo[61:32];
            end
            c = 61'(r_sd[3].sz1) * 61'(r4_m[i][1]) + (61'd1 << 28);
            n_cap[i] = c[60:29];
        end
    end

    // stage 6: box row sums, capsule radius add
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_bs[i] = '0;
            for (int j = 0; j < 3; j++) begin
                n_bs[i] = n_bs[i] + 64'(r5_bh[i][j]) + 64'(r5_bl[i][j]);
            end
            n_cap6[i] = 33'(r5_cap[i]) + 33'(r_sd[4].sz0);
        end
    end

    // stage 7: select by kind, saturate
    always_comb begin
        logic [63:0]           v;
        logic [63:0]           rb;
        logic [2:0][EXT_W-1:0] e;
        logic                  sat;
        sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            rb = r6_bs[i] + 64'd4096;
            unique case (r_sd[5].kind)
                K_SPHERE:  v = 64'(r_sd[5].sph);
                K_BOX:     v = 64'(rb[63:13]);
                K_CAPSULE: v = 64'(r6_cap[i]);
                default:   v = '0;
            endcase
            if (v > 64'(EXT_MAX)) begin
                e[i] = EXT_MAX;
                sat  = 1'b1;
            end else begin
                e[i] = EXT_W'(v);
            end
        end
        n_out.slot      = r_sd[5].slot;
        n_out.ext_x     = e[0];
        n_out.ext_y     = e[1];
        n_out.ext_z     = e[2];
        n_out.updated   = (r_sd[5].kind != K_NONE);
        n_out.saturated = sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= n_sd0;
            r_sd[1] <= n_sd1;
            for (int k = 2; k < NSTG - 1; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            r1_qpw <= quat_prods(i_item.qw);
            r1_qpo <= quat_prods(i_item.qo);
            r1_mx  <= n_mx;
            r2_rw  <= quat_mat(r1_qpw);
            r2_ro  <= quat_mat(r1_qpo);
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 3; k++) begin
                        r3_cp[i][j][k] <= 60'($signed(r2_ro[i][k]) * $signed(r2_rw[k][j]));
                    end
                end
            end
            r4_m   <= n_m;
            r5_bh  <= n_bh;
            r5_bl  <= n_bl;
            r5_cap <= n_cap;
            r6_bs  <= n_bs;
            r6_cap <= n_cap6;
            r_out  <= n_out;
        end
    end

endmodule

// File: design/collider_aabb_extent.sv
// Top level of the collider bounding-box half-extent unit.
// Depends on cae_pkg, cae_front, cae_queue, cae_back.

// Each accepted word describes one collider (sphere, box, capsule or unknown
// kind) and yields exactly one result word carrying the slot number, three
// unsigned Q15.16 half-extents (the box min corner is their negation), an
// updated flag (clear for an unknown kind, extents then zero) and a saturated
// flag set when any extent was clamped to its 31-bit maximum. Throughput is
// one word per clock in steady state while the output side stays ready. When
// nothing stalls, an accepted word is loaded into the front register at the
// accepting edge, then written into the queue, then passes through the seven
// back-end registers before its result is valid. The back-end depth is set by
// the chain quaternion products -> rotation matrices -> matrix product ->
// magnitude rounding -> size/term products -> row sums -> saturation, at most
// one multiplier level per stage.
// The queue (QUEUE_DEPTH words) lets the front keep accepting while the back
// end is held by the output side.
module collider_aabb_extent import cae_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_command,
    input  logic [SLOT_W-1:0]        i_entry_index,
    input  logic [QUAT_W-1:0]        i_world_rotation,
    input  logic [QUAT_W-1:0]        i_offset_rotation,
    input  logic signed [SCL_W-1:0]  i_scale_x,
    input  logic signed [SCL_W-1:0]  i_scale_y,
    input  logic signed [SCL_W-1:0]  i_scale_z,
    input  logic [SZ_W-1:0]          i_size_a,
    input  logic [SZ_W-1:0]          i_size_b,
    input  logic [SZ_W-1:0]          i_size_c,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [SLOT_W-1:0]        o_slot_out,
    output logic [EXT_W-1:0]         o_extent_x,
    output logic [EXT_W-1:0]         o_extent_y,
    output logic [EXT_W-1:0]         o_extent_z,
    output logic                     o_updated,
    output logic                     o_saturated
);

    // front -> queue
    logic    fq_valid;
    logic    fq_ready;
    t_item   fq_item;
    // queue -> back
    logic    qb_valid;
    logic    qb_ready;
    t_item   qb_item;
    t_result res;

    cae_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_command         (i_command),
        .i_entry_index     (i_entry_index),
        .i_world_rotation  (i_world_rotation),
        .i_offset_rotation (i_offset_rotation),
        .i_scale_x         (i_scale_x),
        .i_scale_y         (i_scale_y),
        .i_scale_z         (i_scale_z),
        .i_size_a          (i_size_a),
        .i_size_b          (i_size_b),
        .i_size_c          (i_size_c),
        .o_valid           (fq_valid),
        .i_ready           (fq_ready),
        .o_item            (fq_item)
    );

    cae_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_item  (fq_item),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_item  (qb_item)
    );

    cae_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (qb_valid),
        .o_ready  (qb_ready),
        .i_item   (qb_item),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (res)
    );

    assign o_slot_out  = res.slot;
    assign o_extent_x  = res.ext_x;
    assign o_extent_y  = res.ext_y;
    assign o_extent_z  = res.ext_z;
    assign o_updated   = res.updated;
    assign o_saturated = res.saturated;

endmodule
